// ===== rtl/core/vna_pkg.sv =====
// Shared types and constants for the vertex normal accumulator.
// Depends on nothing; every other file of the block but vna_ram refers to it by scoped names.
`default_nettype none

package vna_pkg;

    // Fixed field widths of the channel words.
    localparam int IDX_W   = 12;
    localparam int COORD_W = 16;
    localparam int NORM_W  = 35;
    localparam int COUNT_W = 8;
    localparam int OP_W    = 2;

    // Face counts stop at this value.
    localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;

    // Index reduction: three conditional subtractions per cycle, and how many such rounds are run.
    localparam int RED_STEPS = 3;
    localparam int RED_CYC   = 4;

    // Divider: quotient bits resolved per cycle, and divisor width (count plus one).
    localparam int DIV_STEPS = 2;
    localparam int DEN_W     = COUNT_W + 1;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD = 2'd0,
        OP_FACE = 2'd1,
        OP_READ = 2'd2,
        OP_NONE = 2'd3
    } t_op;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_REDUCE,
        S_LOAD,
        S_RD_ISSUE,
        S_RD_CAP,
        S_F_RA,
        S_F_RB,
        S_F_RC,
        S_F_RW,
        S_F_DIFF,
        S_F_MUL,
        S_C_RD,
        S_C_CAP,
        S_C_GO,
        S_C_DIV,
        S_C_WR,
        S_EMIT_F,
        S_EMIT_R
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       in_take;
        logic       red_step;
        logic [1:0] red_cyc;
        logic       clr_wr;
        logic       pos_wr;
        logic [1:0] rd_sel;
        logic       cap_vtx;
        logic [1:0] cap_sel;
        logic       diff;
        logic       mul_en;
        logic [1:0] mul_k;
        logic       sub_en;
        logic [1:0] sub_k;
        logic       cap_n;
        logic       div_start;
        logic       nrm_wr;
        logic [1:0] wr_sel;
        logic       out_face;
        logic       out_read;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
        logic div_done;
        logic out_free;
        t_op  op;
    } t_sts;

endpackage

`default_nettype wire

// ===== rtl/core/vna_chan_if.sv =====
// Handshake channel interfaces for the input and result words.
// Depends on vna_pkg for the field widths.
`default_nettype none

interface vna_in_if;
    logic                                valid;
    logic                                ready;
    logic [vna_pkg::OP_W-1:0]            operation;
    logic [vna_pkg::IDX_W-1:0]           index_a;
    logic [vna_pkg::IDX_W-1:0]           index_b;
    logic [vna_pkg::IDX_W-1:0]           index_c;
    logic signed [vna_pkg::COORD_W-1:0]  coord_x;
    logic signed [vna_pkg::COORD_W-1:0]  coord_y;
    logic signed [vna_pkg::COORD_W-1:0]  coord_z;

    modport source (
        output valid, operation, index_a, index_b, index_c, coord_x, coord_y, coord_z,
        input  ready
    );
    modport sink (
        input  valid, operation, index_a, index_b, index_c, coord_x, coord_y, coord_z,
        output ready
    );
endinterface

interface vna_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [vna_pkg::NORM_W-1:0]  normal_x;
    logic signed [vna_pkg::NORM_W-1:0]  normal_y;
    logic signed [vna_pkg::NORM_W-1:0]  normal_z;
    logic [vna_pkg::COUNT_W-1:0]        faces_seen;

    modport source (
        output valid, normal_x, normal_y, normal_z, faces_seen,
        input  ready
    );
    modport sink (
        input  valid, normal_x, normal_y, normal_z, faces_seen,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/core/vna_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
`default_nettype none

module vna_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]              o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/core/vna_div.sv =====
// Three-lane signed divider by a shared small divisor, truncating toward zero.
// Resolves DIV_STEPS quotient bits per cycle. Depends on vna_pkg.
`default_nettype none

module vna_div #(
    parameter int QW = 36
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic signed [QW-1:0]          i_num [3],
    input  wire logic [vna_pkg::DEN_W-1:0]     i_den,
    output logic                               o_done,
    output logic signed [QW-1:0]               o_quo [3]
);

    localparam int DCYC = (QW + vna_pkg::DIV_STEPS - 1) / vna_pkg::DIV_STEPS;
    localparam int PW   = DCYC * vna_pkg::DIV_STEPS;
    localparam int CW   = $clog2(DCYC + 1);
    localparam int DW   = vna_pkg::DEN_W;

    logic                r_busy;
    logic [CW-1:0]       r_cnt;
    logic [DW-1:0]       r_den;
    logic                r_neg [3];
    logic [PW-1:0]       r_dvd [3];
    logic [DW-1:0]       r_rem [3];
    logic [PW-1:0]       n_dvd [3];
    logic [DW-1:0]       n_rem [3];
    logic                w_last;

    assign w_last = (r_cnt == CW'(DCYC - 1));

    // Control: busy flag and cycle counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + CW'(1);
            if (w_last) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Restoring division steps of one iteration, all lanes side by side.
    always_comb begin
        logic [DW:0] t;
        for (int l = 0; l < 3; l++) begin
            n_dvd[l] = r_dvd[l];
            n_rem[l] = r_rem[l];
            for (int s = 0; s < vna_pkg::DIV_STEPS; s++) begin
                t = {n_rem[l], n_dvd[l][PW-1]};
                n_dvd[l] = {n_dvd[l][PW-2:0], 1'b0};
                if (t >= {1'b0, r_den}) begin
                    t = t - {1'b0, r_den};
                    n_dvd[l][0] = 1'b1;
                end
                n_rem[l] = t[DW-1:0];
            end
        end
    end

    // Operand loading and iteration.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den <= i_den;
            for (int l = 0; l < 3; l++) begin
                r_neg[l] <= i_num[l][QW-1];
                r_dvd[l] <= i_num[l][QW-1] ? PW'(unsigned'(-i_num[l]))
                                            : PW'(unsigned'(i_num[l]));
                r_rem[l] <= '0;
            end
        end else if (r_busy) begin
            for (int l = 0; l < 3; l++) begin
                r_dvd[l] <= n_dvd[l];
                r_rem[l] <= n_rem[l];
            end
        end
    end

    // Signed quotients, valid from the cycle after the done pulse.
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            o_quo[l] = r_neg[l] ? -signed'(r_dvd[l][QW-1:0]) : signed'(r_dvd[l][QW-1:0]);
        end
    end

    assign o_done = r_busy && w_last;

endmodule

`default_nettype wire

// ===== rtl/core/vna_datapath.sv =====
// Datapath: position and normal stores, index reduction, cross product,
// blend arithmetic and the output register. Depends on vna_pkg, vna_ram, vna_div.
`default_nettype none

module vna_datapath #(
    parameter int VERTEX_SLOTS = 4096,
    parameter int COORD_BITS   = 16
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire vna_pkg::t_cmd                        i_cmd,
    output vna_pkg::t_sts                             o_sts,
    input  wire logic [vna_pkg::OP_W-1:0]             i_operation,
    input  wire logic [vna_pkg::IDX_W-1:0]            i_index_a,
    input  wire logic [vna_pkg::IDX_W-1:0]            i_index_b,
    input  wire logic [vna_pkg::IDX_W-1:0]            i_index_c,
    input  wire logic signed [vna_pkg::COORD_W-1:0]   i_coord_x,
    input  wire logic signed [vna_pkg::COORD_W-1:0]   i_coord_y,
    input  wire logic signed [vna_pkg::COORD_W-1:0]   i_coord_z,
    input  wire logic                                 i_out_ready,
    output logic                                      o_out_valid,
    output logic signed [vna_pkg::NORM_W-1:0]         o_normal_x,
    output logic signed [vna_pkg::NORM_W-1:0]         o_normal_y,
    output logic signed [vna_pkg::NORM_W-1:0]         o_normal_z,
    output logic [vna_pkg::COUNT_W-1:0]               o_faces_seen
);

    localparam int AW  = $clog2(VERTEX_SLOTS);
    localparam int CB  = COORD_BITS;
    localparam int DW  = CB + 1;
    localparam int PRW = 2 * DW;
    localparam int NW  = 2 * CB + 3;
    localparam int QW  = NW + 1;
    localparam int CW  = vna_pkg::COUNT_W;
    localparam int IW  = vna_pkg::IDX_W;
    localparam int NRW = 3 * NW + CW;

    // Captured item.
    vna_pkg::t_op           r_op;
    logic [IW-1:0]          r_idx [3];
    logic [IW-1:0]          n_idx [3];
    logic signed [CB-1:0]   r_cx, r_cy, r_cz;

    // Clearing pass address.
    logic [AW-1:0]          r_clr;

    // Face arithmetic.
    logic signed [CB-1:0]   r_pos [3][3];
    logic [CW-1:0]          r_oc [3];
    logic signed [DW-1:0]   r_d1 [3];
    logic signed [DW-1:0]   r_d2 [3];
    logic signed [PRW-1:0]  r_p0, r_p1;
    logic signed [NW-1:0]   r_f [3];
    logic signed [NW-1:0]   r_n [3];
    logic [CW-1:0]          r_cur;

    // Output register.
    logic                   r_out_valid;
    logic signed [vna_pkg::NORM_W-1:0] r_ox, r_oy, r_oz;
    logic [CW-1:0]          r_ocnt;

    logic [AW-1:0]          w_addr [3];
    logic [AW-1:0]          w_raddr;
    logic [AW-1:0]          w_naddr;
    logic [3*CB-1:0]        w_pos_rd;
    logic [NRW-1:0]         w_nrm_rd;
    logic [NRW-1:0]         w_nrm_wd;
    logic                   w_nrm_we;
    logic [CW-1:0]          w_cnt_new;
    logic signed [QW-1:0]   w_num [3];
    logic signed [QW-1:0]   w_quo [3];
    logic signed [NW-1:0]   w_blend [3];
    logic [vna_pkg::DEN_W-1:0] w_den;
    logic [CW-1:0]          w_oc_sel;
    logic signed [DW-1:0]   w_ma, w_mb;
    logic signed [DW-1:0]   w_mc, w_md;
    logic                   w_div_done;

    // Item capture and index reduction modulo the slot count.
    always_comb begin
        logic [IW-1:0] rv;
        logic [63:0]   thr;
        int            kk;
        for (int l = 0; l < 3; l++) begin
            rv = r_idx[l];
            for (int j = 0; j < vna_pkg::RED_STEPS; j++) begin
                kk  = IW - 1 - vna_pkg::RED_STEPS * int'(i_cmd.red_cyc) - j;
                thr = 64'(VERTEX_SLOTS) << kk;
                if (64'(rv) >= thr) begin
                    rv = rv - thr[IW-1:0];
                end
            end
            n_idx[l] = rv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.in_take) begin
            r_op     <= vna_pkg::t_op'(i_operation);
            r_idx[0] <= i_index_a;
            r_idx[1] <= i_index_b;
            r_idx[2] <= i_index_c;
            r_cx     <= i_coord_x[CB-1:0];
            r_cy     <= i_coord_y[CB-1:0];
            r_cz     <= i_coord_z[CB-1:0];
        end else if (i_cmd.red_step) begin
            for (int l = 0; l < 3; l++) begin
                r_idx[l] <= n_idx[l];
            end
        end
    end

    // Slot addresses.
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            w_addr[l] = AW'(r_idx[l]);
        end
    end

    always_comb begin
        unique case (i_cmd.rd_sel)
            2'd1:    w_raddr = w_addr[1];
            2'd2:    w_raddr = w_addr[2];
            default: w_raddr = w_addr[0];
        endcase
    end

    // Clearing pass counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clr_wr) begin
            r_clr <= r_clr + AW'(1);
        end
    end

    // Position store: x in the low bits, then y, then z.
    vna_ram #(
        .WIDTH (3 * CB),
        .DEPTH (VERTEX_SLOTS)
    ) u_pos_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.pos_wr),
        .i_waddr (w_addr[0]),
        .i_wdata ({r_cz, r_cy, r_cx}),
        .i_raddr (w_raddr),
        .o_rdata (w_pos_rd)
    );

    // Normal and count store: count on top, then z, y, x.
    always_comb begin
        unique case (i_cmd.wr_sel)
            2'd1:    w_oc_sel = r_oc[1];
            2'd2:    w_oc_sel = r_oc[2];
            default: w_oc_sel = r_oc[0];
        endcase
        if (i_cmd.clr_wr) begin
            w_naddr = r_clr;
        end else begin
            unique case (i_cmd.wr_sel)
                2'd1:    w_naddr = w_addr[1];
                2'd2:    w_naddr = w_addr[2];
                default: w_naddr = w_addr[0];
            endcase
        end
    end

    assign w_cnt_new = (r_cur == vna_pkg::COUNT_MAX) ? r_cur : r_cur + CW'(1);
    assign w_nrm_we  = i_cmd.clr_wr || i_cmd.nrm_wr;
    assign w_nrm_wd  = i_cmd.clr_wr ? '0 : {w_cnt_new, w_blend[2], w_blend[1], w_blend[0]};

    vna_ram #(
        .WIDTH (NRW),
        .DEPTH (VERTEX_SLOTS)
    ) u_nrm_ram (
        .i_clk   (i_clk),
        .i_we    (w_nrm_we),
        .i_waddr (w_naddr),
        .i_wdata (w_nrm_wd),
        .i_raddr (w_raddr),
        .o_rdata (w_nrm_rd)
    );

    // Corner capture: positions and the counts as they stand before the face.
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_vtx) begin
            for (int k = 0; k < 3; k++) begin
                r_pos[i_cmd.cap_sel][k] <= w_pos_rd[k*CB +: CB];
            end
            r_oc[i_cmd.cap_sel] <= w_nrm_rd[3*NW +: CW];
        end
    end

    // Edge vectors.
    always_ff @(posedge i_clk) begin
        if (i_cmd.diff) begin
            for (int k = 0; k < 3; k++) begin
                r_d1[k] <= DW'(r_pos[1][k]) - DW'(r_pos[0][k]);
                r_d2[k] <= DW'(r_pos[2][k]) - DW'(r_pos[0][k]);
            end
        end
    end

    // Cross product, one component per cycle: products, then their difference.
    always_comb begin
        unique case (i_cmd.mul_k)
            2'd1: begin
                w_ma = r_d1[2]; w_mb = r_d2[0]; w_mc = r_d1[0]; w_md = r_d2[2];
            end
            2'd2: begin
                w_ma = r_d1[0]; w_mb = r_d2[1]; w_mc = r_d1[1]; w_md = r_d2[0];
            end
            default: begin
                w_ma = r_d1[1]; w_mb = r_d2[2]; w_mc = r_d1[2]; w_md = r_d2[1];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_p0 <= PRW'(w_ma) * PRW'(w_mb);
            r_p1 <= PRW'(w_mc) * PRW'(w_md);
        end
        if (i_cmd.sub_en) begin
            r_f[i_cmd.sub_k] <= NW'(r_p0) - NW'(r_p1);
        end
    end

    // Current mean and count of the slot being worked on.
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_n) begin
            for (int k = 0; k < 3; k++) begin
                r_n[k] <= w_nrm_rd[k*NW +: NW];
            end
            r_cur <= w_nrm_rd[3*NW +: CW];
        end
    end

    // Blend: n + (f - n) / (count + 1).
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_num[k]   = QW'(r_f[k]) - QW'(r_n[k]);
            w_blend[k] = NW'(QW'(r_n[k]) + w_quo[k]);
        end
    end

    assign w_den = vna_pkg::DEN_W'(w_oc_sel) + vna_pkg::DEN_W'(1);

    vna_div #(
        .QW (QW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    // Output register: holds a word until it is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_face || i_cmd.out_read) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_face) begin
            r_ox   <= vna_pkg::NORM_W'(r_f[0]);
            r_oy   <= vna_pkg::NORM_W'(r_f[1]);
            r_oz   <= vna_pkg::NORM_W'(r_f[2]);
            r_ocnt <= '0;
        end else if (i_cmd.out_read) begin
            r_ox   <= vna_pkg::NORM_W'(r_n[0]);
            r_oy   <= vna_pkg::NORM_W'(r_n[1]);
            r_oz   <= vna_pkg::NORM_W'(r_n[2]);
            r_ocnt <= r_cur;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_normal_x   = r_ox;
    assign o_normal_y   = r_oy;
    assign o_normal_z   = r_oz;
    assign o_faces_seen = r_ocnt;

    // Status back to the controller.
    assign o_sts.clr_last = (r_clr == AW'(VERTEX_SLOTS - 1));
    assign o_sts.div_done = w_div_done;
    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_sts.op       = r_op;

`ifndef SYNTHESIS
    // A position is only written at a fully reduced slot index.
    a_pos_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pos_wr |-> (64'(r_idx[0]) < 64'(VERTEX_SLOTS)))
        else $error("position write at unreduced index");

    // Clearing and blend writes never share the write port.
    a_wr_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clr_wr |-> !i_cmd.nrm_wr)
        else $error("clear and blend write together");

    // A blend never leaves a count of zero behind.
    a_cnt_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.nrm_wr |-> (w_cnt_new != '0))
        else $error("blend wrote a zero count");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/vna_ctrl.sv =====
// Controller state machine: sequences clearing, loads, reads and face updates.
// Depends on vna_pkg.
`default_nettype none

module vna_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire vna_pkg::t_sts   i_sts,
    output vna_pkg::t_cmd        o_cmd
);

    vna_pkg::t_state r_state, n_state;
    logic [1:0]      r_step, n_step;
    logic [1:0]      r_corner, n_corner;

    // State and counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= vna_pkg::S_CLEAR;
            r_step   <= '0;
            r_corner <= '0;
        end else begin
            r_state  <= n_state;
            r_step   <= n_step;
            r_corner <= n_corner;
        end
    end

    // Next state.
    always_comb begin
        n_state  = r_state;
        n_step   = '0;
        n_corner = r_corner;
        unique case (r_state)
            vna_pkg::S_CLEAR: begin
                if (i_sts.clr_last) n_state = vna_pkg::S_IDLE;
            end
            vna_pkg::S_IDLE: begin
                n_corner = '0;
                if (i_in_valid) n_state = vna_pkg::S_REDUCE;
            end
            vna_pkg::S_REDUCE: begin
                n_step = r_step + 2'd1;
                if (r_step == 2'(vna_pkg::RED_CYC - 1)) begin
                    unique case (i_sts.op)
                        vna_pkg::OP_LOAD: n_state = vna_pkg::S_LOAD;
                        vna_pkg::OP_FACE: n_state = vna_pkg::S_F_RA;
                        vna_pkg::OP_READ: n_state = vna_pkg::S_RD_ISSUE;
                        vna_pkg::OP_NONE: n_state = vna_pkg::S_IDLE;
                    endcase
                end
            end
            vna_pkg::S_LOAD:     n_state = vna_pkg::S_IDLE;
            vna_pkg::S_RD_ISSUE: n_state = vna_pkg::S_RD_CAP;
            vna_pkg::S_RD_CAP:   n_state = vna_pkg::S_EMIT_R;
            vna_pkg::S_F_RA:     n_state = vna_pkg::S_F_RB;
            vna_pkg::S_F_RB:     n_state = vna_pkg::S_F_RC;
            vna_pkg::S_F_RC:     n_state = vna_pkg::S_F_RW;
            vna_pkg::S_F_RW:     n_state = vna_pkg::S_F_DIFF;
            vna_pkg::S_F_DIFF:   n_state = vna_pkg::S_F_MUL;
            vna_pkg::S_F_MUL: begin
                n_step = r_step + 2'd1;
                if (r_step == 2'd3) n_state = vna_pkg::S_C_RD;
            end
            vna_pkg::S_C_RD:  n_state = vna_pkg::S_C_CAP;
            vna_pkg::S_C_CAP: n_state = vna_pkg::S_C_GO;
            vna_pkg::S_C_GO:  n_state = vna_pkg::S_C_DIV;
            vna_pkg::S_C_DIV: begin
                if (i_sts.div_done) n_state = vna_pkg::S_C_WR;
            end
            vna_pkg::S_C_WR: begin
                if (r_corner == 2'd2) begin
                    n_state  = vna_pkg::S_EMIT_F;
                    n_corner = '0;
                end else begin
                    n_state  = vna_pkg::S_C_RD;
                    n_corner = r_corner + 2'd1;
                end
            end
            vna_pkg::S_EMIT_F, vna_pkg::S_EMIT_R: begin
                if (i_sts.out_free) n_state = vna_pkg::S_IDLE;
            end
            default: n_state = vna_pkg::S_IDLE;
        endcase
    end

    // Commands to the datapath.
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            vna_pkg::S_CLEAR: o_cmd.clr_wr = 1'b1;
            vna_pkg::S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.in_take = i_in_valid;
            end
            vna_pkg::S_REDUCE: begin
                o_cmd.red_step = 1'b1;
                o_cmd.red_cyc  = r_step;
            end
            vna_pkg::S_LOAD:     o_cmd.pos_wr = 1'b1;
            vna_pkg::S_RD_ISSUE: o_cmd.rd_sel = 2'd0;
            vna_pkg::S_RD_CAP:   o_cmd.cap_n  = 1'b1;
            vna_pkg::S_F_RA:     o_cmd.rd_sel = 2'd0;
            vna_pkg::S_F_RB: begin
                o_cmd.rd_sel  = 2'd1;
                o_cmd.cap_vtx = 1'b1;
                o_cmd.cap_sel = 2'd0;
            end
            vna_pkg::S_F_RC: begin
                o_cmd.rd_sel  = 2'd2;
                o_cmd.cap_vtx = 1'b1;
                o_cmd.cap_sel = 2'd1;
            end
            vna_pkg::S_F_RW: begin
                o_cmd.cap_vtx = 1'b1;
                o_cmd.cap_sel = 2'd2;
            end
            vna_pkg::S_F_DIFF: o_cmd.diff = 1'b1;
            vna_pkg::S_F_MUL: begin
                o_cmd.mul_en = (r_step != 2'd3);
                o_cmd.mul_k  = r_step;
                o_cmd.sub_en = (r_step != 2'd0);
                o_cmd.sub_k  = r_step - 2'd1;
            end
            vna_pkg::S_C_RD:  o_cmd.rd_sel = r_corner;
            vna_pkg::S_C_CAP: o_cmd.cap_n  = 1'b1;
            vna_pkg::S_C_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.wr_sel    = r_corner;
            end
            vna_pkg::S_C_DIV: o_cmd.wr_sel = r_corner;
            vna_pkg::S_C_WR: begin
                o_cmd.nrm_wr = 1'b1;
                o_cmd.wr_sel = r_corner;
            end
            vna_pkg::S_EMIT_F: o_cmd.out_face = i_sts.out_free;
            vna_pkg::S_EMIT_R: o_cmd.out_read = i_sts.out_free;
            default: o_cmd = '0;
        endcase
    end

`ifndef SYNTHESIS
    // Only three corners exist.
    a_corner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_corner != 2'd3)
        else $error("corner counter out of range");

    // A result word is only loaded when the output register can take it.
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.out_face || o_cmd.out_read) |-> i_sts.out_free)
        else $error("result loaded over a waiting word");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/vertex_normal_accumulator.sv =====
// Top level of the vertex normal accumulator: controller plus datapath.
// Depends on vna_pkg, vna_chan_if, vna_ctrl and vna_datapath.
//
//   Channel  Dir  Handshake          Word
//   i_in     in   valid / ready      operation, index_a..c, coord_x..z
//   o_out    out  valid / ready      normal_x..z, faces_seen
//
// After reset a clearing pass writes zero to every normal and count slot,
// one slot a cycle; no word is taken meanwhile. Words are handled one at a
// time. A face takes longest: the divider, resolving two bits a cycle, runs
// for each of the three corner updates. A waiting result does not stop the
// next word being taken; only the next result waits for the output register.
`default_nettype none

module vertex_normal_accumulator #(
    parameter int VERTEX_SLOTS = 4096,
    parameter int COORD_BITS   = 16
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    vna_in_if.sink     i_in,
    vna_out_if.source  o_out
);

    vna_pkg::t_cmd w_cmd;
    vna_pkg::t_sts w_sts;

    // Sequencer.
    vna_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // Stores and arithmetic.
    vna_datapath #(
        .VERTEX_SLOTS (VERTEX_SLOTS),
        .COORD_BITS   (COORD_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_operation  (i_in.operation),
        .i_index_a    (i_in.index_a),
        .i_index_b    (i_in.index_b),
        .i_index_c    (i_in.index_c),
        .i_coord_x    (i_in.coord_x),
        .i_coord_y    (i_in.coord_y),
        .i_coord_z    (i_in.coord_z),
        .i_out_ready  (o_out.ready),
        .o_out_valid  (o_out.valid),
        .o_normal_x   (o_out.normal_x),
        .o_normal_y   (o_out.normal_y),
        .o_normal_z   (o_out.normal_z),
        .o_faces_seen (o_out.faces_seen)
    );

endmodule

`default_nettype wire
